// File: hdl/cgps_pkg.sv
// shared widths, payload types and arithmetic helpers of the particle step pipeline
package cgps_pkg;

    localparam int VW        = 48;   // position and velocity width
    localparam int FW        = 40;   // fraction bits
    localparam int TS_W      = 42;
    localparam int GM_W      = 40;
    localparam int K_W       = 82;   // gravity_mass * time_scale
    localparam int S_W       = 96;   // squared distance
    localparam int R_W       = 48;   // radius
    localparam int F_W       = 41;   // direction ratio, at most 1.0 unless the radius is zero
    localparam int WQ_W      = 88;   // pull factor quotient bits kept
    localparam int WC_W      = 89;   // pull factor after clamp to 2^88
    localparam int DV_W      = 49;   // velocity change magnitude
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 42;

    localparam int SQRT_STEPS   = 48;
    localparam int F_STEPS      = 41;
    localparam int CORE_STEPS   = 89;
    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 7;
    localparam int DEPTH        = FRONT_STAGES + CORE_STEPS + BACK_STAGES;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_MASS = 1'd1;

    localparam logic [TS_W-1:0] TS_RESET = 42'd549755813888;
    localparam logic [GM_W-1:0] GM_RESET = 40'd7337965;

    localparam logic signed [51:0] VMAX = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [51:0] VMIN = 52'shF_8000_0000_0000;

    typedef logic [2:0][VW-1:0] t_vec3;

    typedef struct packed {
        t_vec3                pos;
        t_vec3                vel;
        t_vec3                mag;
        logic                 zero;
        logic [S_W-1:0]       s;
        logic                 wovf;
        logic [S_W-1:0]       wrem;
        logic [WQ_W-1:0]      wq;
        logic [R_W-1:0]       sres;
        logic [R_W+1:0]       srem;
        t_vec3                frem;
        logic [2:0][F_W-1:0]  fq;
    } t_core;

    typedef struct packed {
        logic [VW-1:0] val;
        logic          ovf;
    } t_sat;

    function automatic t_sat sat_vec(input logic signed [51:0] x);
        t_sat res;
        if (x > VMAX) begin
            res.val = VMAX[VW-1:0];
            res.ovf = 1'b1;
        end else if (x < VMIN) begin
            res.val = VMIN[VW-1:0];
            res.ovf = 1'b1;
        end else begin
            res.val = x[VW-1:0];
            res.ovf = 1'b0;
        end
        return res;
    endfunction

    // two's complement magnitude, most negative value reads as 2^47
    function automatic logic [VW-1:0] abs_vec(input logic [VW-1:0] x);
        return x[VW-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

// File: hdl/cgps_if.sv
// valid/ready channels for particle state in and updated particle state out
interface cgps_in_if;
    import cgps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] pos_x;
    logic signed [VW-1:0] pos_y;
    logic signed [VW-1:0] pos_z;
    logic signed [VW-1:0] vel_x;
    logic signed [VW-1:0] vel_y;
    logic signed [VW-1:0] vel_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output vel_x, output vel_y, output vel_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input vel_x, input vel_y, input vel_z, output ready);
endinterface

interface cgps_out_if;
    import cgps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] new_pos_x;
    logic signed [VW-1:0] new_pos_y;
    logic signed [VW-1:0] new_pos_z;
    logic signed [VW-1:0] new_vel_x;
    logic signed [VW-1:0] new_vel_y;
    logic signed [VW-1:0] new_vel_z;
    logic                 zero_radius;
    logic                 saturated;

    modport source (output valid, output new_pos_x, output new_pos_y, output new_pos_z,
                    output new_vel_x, output new_vel_y, output new_vel_z,
                    output zero_radius, output saturated, input ready);
    modport sink   (input valid, input new_pos_x, input new_pos_y, input new_pos_z,
                    input new_vel_x, input new_vel_y, input new_vel_z,
                    input zero_radius, input saturated, output ready);
endinterface

// File: hdl/cgps_front.sv
// front stages: magnitudes, split squares and the squared distance
module cgps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cgps_pkg::t_vec3 i_pos,
    input  cgps_pkg::t_vec3 i_vel,
    output logic            o_valid,
    output cgps_pkg::t_core o_core
);
    import cgps_pkg::*;

    logic [FRONT_STAGES-1:0] r_v;

    t_vec3 r_pos0, r_vel0, r_mag0, n_mag0;
    logic  r_zero0, n_zero0;

    t_vec3 r_pos1, r_vel1, r_mag1;
    logic  r_zero1;
    logic [2:0][2*(VW/2)-1:0] r_p11, r_p10, r_p00, n_p11, n_p10, n_p00;

    t_vec3 r_pos2, r_vel2, r_mag2;
    logic  r_zero2;
    logic [2:0][S_W-1:0] r_sq, n_sq;

    t_core r_core, n_core;

    always_comb begin
        logic [VW/2-1:0] hi, lo;
        for (int i = 0; i < 3; i++) begin
            n_mag0[i] = abs_vec(i_pos[i]);
        end
        n_zero0 = (i_pos == '0);

        // a^2 = hi^2 * 2^48 + 2*hi*lo * 2^24 + lo^2
        for (int i = 0; i < 3; i++) begin
            hi = r_mag0[i][VW-1:VW/2];
            lo = r_mag0[i][VW/2-1:0];
            n_p11[i] = VW'(hi) * VW'(hi);
            n_p10[i] = VW'(hi) * VW'(lo);
            n_p00[i] = VW'(lo) * VW'(lo);
        end

        for (int i = 0; i < 3; i++) begin
            n_sq[i] = {r_p11[i], {VW{1'b0}}} + {23'd0, r_p10[i], 25'd0}
                    + {{VW{1'b0}}, r_p00[i]};
        end

        n_core      = '0;
        n_core.pos  = r_pos2;
        n_core.vel  = r_vel2;
        n_core.mag  = r_mag2;
        n_core.zero = r_zero2;
        n_core.s    = r_sq[0] + r_sq[1] + r_sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos0  <= i_pos;
            r_vel0  <= i_vel;
            r_mag0  <= n_mag0;
            r_zero0 <= n_zero0;

            r_pos1  <= r_pos0;
            r_vel1  <= r_vel0;
            r_mag1  <= r_mag0;
            r_zero1 <= r_zero0;
            r_p11   <= n_p11;
            r_p10   <= n_p10;
            r_p00   <= n_p00;

            r_pos2  <= r_pos1;
            r_vel2  <= r_vel1;
            r_mag2  <= r_mag1;
            r_zero2 <= r_zero1;
            r_sq    <= n_sq;

            r_core  <= n_core;
        end
    end

    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_core  = r_core;

endmodule

// File: hdl/cgps_step.sv
// one stage of the shared iteration: a pull factor quotient bit, past the first stage, and
// a root bit or a direction ratio bit per component, depending on the stage position
module cgps_step #(
    parameter int J = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [cgps_pkg::K_W-1:0]  i_k,
    input  logic                      i_valid,
    input  cgps_pkg::t_core           i_core,
    output logic                      o_valid,
    output cgps_pkg::t_core           o_core
);
    import cgps_pkg::*;

    logic             r_v;
    t_core            r_core, n_core;

    logic             w_ovf;
    logic [S_W-1:0]   w_rem;
    logic [WQ_W-1:0]  w_q;
    logic [R_W+1:0]   q_rem;
    logic [R_W-1:0]   q_res;
    t_vec3            f_rem;
    logic [2:0][F_W-1:0] f_q;

    // pull factor: numerator is k * 2^40, a quotient of 2^88 or more only flagged
    if (J == 0) begin : g_winit
        logic [S_W-1:0] top;
        assign top   = {{(S_W-(K_W-WQ_W+FW)){1'b0}}, i_k[K_W-1:WQ_W-FW]};
        assign w_ovf = (top >= i_core.s);
        assign w_rem = top;
        assign w_q   = '0;
    end else begin : g_wstep
        logic         w_bit;
        logic [S_W:0] rem2;
        logic [S_W:0] diff;
        logic         ge;
        if (J <= WQ_W - FW) begin : g_kbit
            assign w_bit = i_k[WQ_W - FW - J];
        end else begin : g_zbit
            assign w_bit = 1'b0;
        end
        assign rem2  = {i_core.wrem, w_bit};
        assign diff  = rem2 - {1'b0, i_core.s};
        assign ge    = (rem2 >= {1'b0, i_core.s});
        assign w_ovf = i_core.wovf;
        assign w_rem = ge ? diff[S_W-1:0] : rem2[S_W-1:0];
        assign w_q   = {i_core.wq[WQ_W-2:0], ge};
    end

    // square root, two radicand bits a stage
    if (J < SQRT_STEPS) begin : g_sqrt
        logic [R_W+3:0] rem2;
        logic [R_W+3:0] trial;
        logic [R_W+3:0] diff;
        logic           ge;
        assign rem2  = {i_core.srem, i_core.s[S_W-1-2*J -: 2]};
        assign trial = {2'b00, i_core.sres, 2'b01};
        assign diff  = rem2 - trial;
        assign ge    = (rem2 >= trial);
        assign q_rem = ge ? diff[R_W+1:0] : rem2[R_W+1:0];
        assign q_res = {i_core.sres[R_W-2:0], ge};
    end else begin : g_sqrt_hold
        assign q_rem = i_core.srem;
        assign q_res = i_core.sres;
    end

    // direction ratio a_i * 2^40 / r, the first stage loads a_i itself
    if (J >= SQRT_STEPS) begin : g_ratio
        for (genvar i = 0; i < 3; i++) begin : g_comp
            logic [R_W:0] rem2;
            logic [R_W:0] diff;
            logic         ge;
            if (J == SQRT_STEPS) begin : g_load
                assign rem2 = {1'b0, i_core.mag[i]};
            end else begin : g_shift
                assign rem2 = {i_core.frem[i], 1'b0};
            end
            assign diff     = rem2 - {1'b0, i_core.sres};
            assign ge       = (rem2 >= {1'b0, i_core.sres});
            assign f_rem[i] = ge ? diff[R_W-1:0] : rem2[R_W-1:0];
            assign f_q[i]   = {i_core.fq[i][F_W-2:0], ge};
        end
    end else begin : g_ratio_hold
        assign f_rem = i_core.frem;
        assign f_q   = i_core.fq;
    end

    always_comb begin
        n_core      = i_core;
        n_core.wovf = w_ovf;
        n_core.wrem = w_rem;
        n_core.wq   = w_q;
        n_core.srem = q_rem;
        n_core.sres = q_res;
        n_core.frem = f_rem;
        n_core.fq   = f_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_core <= n_core;
        end
    end

    assign o_valid = r_v;
    assign o_core  = r_core;

endmodule

// File: hdl/cgps_back.sv
// back stages: velocity change product, velocity update, speed, step product, position update
module cgps_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [cgps_pkg::TS_W-1:0] i_ts,
    input  logic                      i_valid,
    input  cgps_pkg::t_core           i_core,
    output logic                      o_valid,
    output cgps_pkg::t_vec3           o_pos,
    output cgps_pkg::t_vec3           o_vel,
    output logic                      o_zero,
    output logic                      o_sat
);
    import cgps_pkg::*;

    localparam int PW = F_W + WC_W;   // ratio times pull factor
    localparam int MW = VW + TS_W;    // speed times time step

    logic [BACK_STAGES-1:0] r_v;

    // stage 0: partial products of ratio and pull factor
    t_vec3 r_pos0, r_vel0;
    logic  r_zero0;
    logic [2:0][63:0] r_pp00, r_pp01, n_pp00, n_pp01;
    logic [2:0][56:0] r_pp02, n_pp02;
    logic [2:0][40:0] r_pp10, r_pp11, n_pp10, n_pp11;
    logic [2:0][33:0] r_pp12, n_pp12;

    // stage 1: velocity change magnitude
    t_vec3 r_pos1, r_vel1;
    logic  r_zero1;
    logic [2:0][DV_W-1:0] r_dv, n_dv;

    // stage 2: new velocity
    t_vec3 r_pos2, r_nv2, n_nv2;
    logic  r_zero2, r_sat2, n_sat2;

    // stage 3: speed
    t_vec3 r_pos3, r_nv3, r_mv, n_mv;
    logic  r_zero3, r_sat3;

    // stage 4: partial products of speed and time step
    t_vec3 r_pos4, r_nv4;
    logic  r_zero4, r_sat4;
    logic [2:0][63:0] r_q00, n_q00;
    logic [2:0][41:0] r_q01, n_q01;
    logic [2:0][47:0] r_q10, n_q10;
    logic [2:0][25:0] r_q11, n_q11;

    // stage 5: position change magnitude
    t_vec3 r_pos5, r_nv5;
    logic  r_zero5, r_sat5;
    logic [2:0][MW-FW-1:0] r_m, n_m;

    // stage 6: result
    t_vec3 r_np, n_np, r_nv6;
    logic  r_zero6, r_sat6, n_sat6;

    always_comb begin
        logic [WC_W-1:0]   wc;
        logic [31:0]       f0, w0, w1, m0, t0;
        logic [8:0]        f1;
        logic [24:0]       w2;
        logic [15:0]       m1;
        logic [9:0]        t1;
        logic [PW-1:0]     prod;
        logic [MW-1:0]     mprod;
        logic [VW+1:0]     vs, vsum;
        logic signed [51:0] ps, dp;
        t_sat              sv, sp;

        wc = i_core.wovf ? {1'b1, {WQ_W{1'b0}}} : {1'b0, i_core.wq};
        w0 = wc[31:0];
        w1 = wc[63:32];
        w2 = wc[WC_W-1:64];
        for (int i = 0; i < 3; i++) begin
            f0 = i_core.fq[i][31:0];
            f1 = i_core.fq[i][F_W-1:32];
            n_pp00[i] = 64'(f0) * 64'(w0);
            n_pp01[i] = 64'(f0) * 64'(w1);
            n_pp02[i] = 57'(f0) * 57'(w2);
            n_pp10[i] = 41'(f1) * 41'(w0);
            n_pp11[i] = 41'(f1) * 41'(w1);
            n_pp12[i] = 34'(f1) * 34'(w2);
        end

        // a change of 2^48 or more saturates the velocity unless the radius is zero
        for (int i = 0; i < 3; i++) begin
            prod = {66'd0, r_pp00[i]} + {34'd0, r_pp01[i], 32'd0}
                 + {57'd0, r_pp10[i], 32'd0} + {9'd0, r_pp02[i], 64'd0}
                 + {25'd0, r_pp11[i], 64'd0} + {r_pp12[i], 96'd0};
            n_dv[i] = (prod[PW-1:WQ_W] != '0) ? {1'b1, {VW{1'b0}}}
                                              : {1'b0, prod[WQ_W-1:FW]};
        end

        n_sat2 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            vs   = {{2{r_vel1[i][VW-1]}}, r_vel1[i]};
            vsum = r_pos1[i][VW-1] ? vs + {1'b0, r_dv[i]} : vs - {1'b0, r_dv[i]};
            sv   = sat_vec({{2{vsum[VW+1]}}, vsum});
            if (r_zero1) begin
                n_nv2[i] = r_vel1[i];
            end else begin
                n_nv2[i] = sv.val;
                n_sat2   = n_sat2 | sv.ovf;
            end
        end

        for (int i = 0; i < 3; i++) begin
            n_mv[i] = abs_vec(r_nv2[i]);
        end

        for (int i = 0; i < 3; i++) begin
            m0 = r_mv[i][31:0];
            m1 = r_mv[i][VW-1:32];
            t0 = i_ts[31:0];
            t1 = i_ts[TS_W-1:32];
            n_q00[i] = 64'(m0) * 64'(t0);
            n_q01[i] = 42'(m0) * 42'(t1);
            n_q10[i] = 48'(m1) * 48'(t0);
            n_q11[i] = 26'(m1) * 26'(t1);
        end

        for (int i = 0; i < 3; i++) begin
            mprod = {26'd0, r_q00[i]} + {16'd0, r_q01[i], 32'd0}
                  + {10'd0, r_q10[i], 32'd0} + {r_q11[i], 64'd0};
            n_m[i] = mprod[MW-1:FW];
        end

        // step truncates toward zero, so the sign goes on after the product
        n_sat6 = r_sat5;
        for (int i = 0; i < 3; i++) begin
            dp = r_nv5[i][VW-1] ? -$signed({2'b00, r_m[i]}) : $signed({2'b00, r_m[i]});
            ps = $signed({{4{r_pos5[i][VW-1]}}, r_pos5[i]}) + dp;
            sp = sat_vec(ps);
            n_np[i] = sp.val;
            n_sat6  = n_sat6 | sp.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[BACK_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos0  <= i_core.pos;
            r_vel0  <= i_core.vel;
            r_zero0 <= i_core.zero;
            r_pp00  <= n_pp00;
            r_pp01  <= n_pp01;
            r_pp02  <= n_pp02;
            r_pp10  <= n_pp10;
            r_pp11  <= n_pp11;
            r_pp12  <= n_pp12;

            r_pos1  <= r_pos0;
            r_vel1  <= r_vel0;
            r_zero1 <= r_zero0;
            r_dv    <= n_dv;

            r_pos2  <= r_pos1;
            r_nv2   <= n_nv2;
            r_zero2 <= r_zero1;
            r_sat2  <= n_sat2;

            r_pos3  <= r_pos2;
            r_nv3   <= r_nv2;
            r_mv    <= n_mv;
            r_zero3 <= r_zero2;
            r_sat3  <= r_sat2;

            r_pos4  <= r_pos3;
            r_nv4   <= r_nv3;
            r_zero4 <= r_zero3;
            r_sat4  <= r_sat3;
            r_q00   <= n_q00;
            r_q01   <= n_q01;
            r_q10   <= n_q10;
            r_q11   <= n_q11;

            r_pos5  <= r_pos4;
            r_nv5   <= r_nv4;
            r_zero5 <= r_zero4;
            r_sat5  <= r_sat4;
            r_m     <= n_m;

            r_np    <= n_np;
            r_nv6   <= r_nv5;
            r_zero6 <= r_zero5;
            r_sat6  <= n_sat6;
        end
    end

    assign o_valid = r_v[BACK_STAGES-1];
    assign o_pos   = r_np;
    assign o_vel   = r_nv6;
    assign o_zero  = r_zero6;
    assign o_sat   = r_sat6;

endmodule

// File: hdl/central_gravity_particle_step.sv
// top level: one semi-implicit Euler step toward the origin per particle
//
//  channel    dir  handshake      carries
//  i_in       in   valid/ready    pos_x pos_y pos_z vel_x vel_y vel_z
//  o_out      out  valid/ready    new_pos/new_vel xyz, zero_radius, saturated
//  i_cfg_*    in   write enable   time_scale (0), gravity_mass (1)
//
// one particle a cycle through 100 stages while the output is not stalled;
// the length is set by the 88-bit pull factor divide, one quotient bit a stage,
// with the root and the direction ratios running beside it
// reset clears the stage valid bits and loads the default registers
// a stalled result holds every stage in place; ready follows the output slot
// a register write reaches the gravity product by way of the registered partial products
module central_gravity_particle_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cgps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cgps_pkg::CFG_W-1:0]     i_cfg_data,
    cgps_in_if.sink                        i_in,
    cgps_out_if.source                     o_out
);
    import cgps_pkg::*;

    logic [TS_W-1:0] r_ts;
    logic [GM_W-1:0] r_gm;
    logic [63:0]     r_kp00;
    logic [41:0]     r_kp01;
    logic [39:0]     r_kp10;
    logic [17:0]     r_kp11;
    logic [K_W-1:0]  r_k;

    logic            en;
    t_vec3           in_pos, in_vel;
    logic [CORE_STEPS:0] c_valid;
    t_core           c_core [CORE_STEPS+1];
    logic            b_valid, b_zero, b_sat;
    t_vec3           b_pos, b_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= TS_RESET;
            r_gm <= GM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIME_SCALE:   r_ts <= i_cfg_data[TS_W-1:0];
                REG_GRAVITY_MASS: r_gm <= i_cfg_data[GM_W-1:0];
                default: ;
            endcase
        end
    end

    // gravity_mass * time_scale, registered partial products then the sum
    always_ff @(posedge i_clk) begin
        r_kp00 <= 64'(r_gm[31:0]) * 64'(r_ts[31:0]);
        r_kp01 <= 42'(r_gm[31:0]) * 42'(r_ts[TS_W-1:32]);
        r_kp10 <= 40'(r_gm[GM_W-1:32]) * 40'(r_ts[31:0]);
        r_kp11 <= 18'(r_gm[GM_W-1:32]) * 18'(r_ts[TS_W-1:32]);
        r_k    <= {18'd0, r_kp00} + {8'd0, r_kp01, 32'd0}
                + {10'd0, r_kp10, 32'd0} + {r_kp11, 64'd0};
    end

    assign en         = ~o_out.valid | o_out.ready;
    assign i_in.ready = en;
    assign in_pos     = {i_in.pos_z, i_in.pos_y, i_in.pos_x};
    assign in_vel     = {i_in.vel_z, i_in.vel_y, i_in.vel_x};

    cgps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_pos   (in_pos),
        .i_vel   (in_vel),
        .o_valid (c_valid[0]),
        .o_core  (c_core[0])
    );

    for (genvar j = 0; j < CORE_STEPS; j++) begin : g_step
        cgps_step #(.J(j)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_k     (r_k),
            .i_valid (c_valid[j]),
            .i_core  (c_core[j]),
            .o_valid (c_valid[j+1]),
            .o_core  (c_core[j+1])
        );
    end

    cgps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ts    (r_ts),
        .i_valid (c_valid[CORE_STEPS]),
        .i_core  (c_core[CORE_STEPS]),
        .o_valid (b_valid),
        .o_pos   (b_pos),
        .o_vel   (b_vel),
        .o_zero  (b_zero),
        .o_sat   (b_sat)
    );

    assign o_out.valid       = b_valid;
    assign o_out.new_pos_x   = b_pos[0];
    assign o_out.new_pos_y   = b_pos[1];
    assign o_out.new_pos_z   = b_pos[2];
    assign o_out.new_vel_x   = b_vel[0];
    assign o_out.new_vel_y   = b_vel[1];
    assign o_out.new_vel_z   = b_vel[2];
    assign o_out.zero_radius = b_zero;
    assign o_out.saturated   = b_sat;

endmodule

// File: hdl/cgps_checker.sv
// port-level checks of the particle step block and their binding
module cgps_port_checks (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [289:0] i_out_payload
);
    import cgps_pkg::*;

    logic [7:0] r_count;
    logic       in_xfer, out_xfer;

    assign in_xfer  = i_in_valid & i_in_ready;
    assign out_xfer = i_out_valid & i_out_ready;

    // particles inside the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + 8'(in_xfer) - 8'(out_xfer);
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("stalled result changed or vanished");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while the pipeline is stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_count != 8'd0)
        else $error("result without a particle in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 8'(DEPTH))
        else $error("more particles in flight than pipeline stages");

endmodule

bind central_gravity_particle_step cgps_port_checks u_cgps_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload ({o_out.new_pos_x, o_out.new_pos_y, o_out.new_pos_z,
                     o_out.new_vel_x, o_out.new_vel_y, o_out.new_vel_z,
                     o_out.zero_radius, o_out.saturated})
);
